[hdl/pbc_pkg.sv]
// Shared types and constants for the PRBS9 bit error rate checker.
// No dependencies; used by pbc_ctrl, pbc_dp and prbs9_ber_checker_unit.

package pbc_pkg;

  // input item actions
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_BYTE   = 2'd1,
    ACT_EMPTY  = 2'd2,
    ACT_REPORT = 2'd3
  } action_t;

  // configuration register index (word address bit)
  localparam logic REG_EXP_LEN = 1'b0;

  localparam int          MAX_PAYLOAD  = 256;
  localparam logic [8:0]  LFSR_SEED    = 9'h1FF;
  localparam logic [8:0]  LEN_RESET    = 9'd64;
  localparam logic [19:0] PPM_SCALE    = 20'd1000000;
  localparam int          QUO_BITS     = 20;
  localparam int          PROD_W       = 32 + QUO_BITS;
  localparam int          STEP_W       = $clog2(QUO_BITS);

  // controller to datapath commands
  typedef struct packed {
    logic clear;        // zero counters, restart packet
    logic byte_in;      // compare one received byte
    logic empty;        // empty packet
    logic rpt_start;    // capture sent count, errors times one million
    logic div_load;     // seed the divider
    logic div_step;     // one quotient bit
    logic finish;       // load the result registers
  } cmd_t;

endpackage

[hdl/pbc_ctrl.sv]
// Sequencer for the PRBS9 checker: input handshake, report division steps
// and the output register handshake. Depends on pbc_pkg.

module pbc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     action,
  input  logic           out_stall,
  output logic           in_stall,
  output logic           out_valid,
  output pbc_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t                      state;
  logic [pbc_pkg::STEP_W-1:0]  step;
  logic                        accept;
  logic                        out_free;
  logic                        last_step;

  localparam logic [pbc_pkg::STEP_W-1:0] LastStep = pbc_pkg::STEP_W'(pbc_pkg::QUO_BITS - 1);

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last_step = (step == LastStep);

  always_comb begin
    cmd           = '0;
    cmd.clear     = accept && (action == pbc_pkg::ACT_CLEAR);
    cmd.byte_in   = accept && (action == pbc_pkg::ACT_BYTE);
    cmd.empty     = accept && (action == pbc_pkg::ACT_EMPTY);
    cmd.rpt_start = accept && (action == pbc_pkg::ACT_REPORT);
    cmd.div_load  = (state == S_MUL);
    cmd.div_step  = (state == S_DIV);
    cmd.finish    = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.rpt_start) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (last_step) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_report_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.rpt_start |=> state == S_MUL)
    else $error("report accepted without starting the multiply");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && last_step |=> state == S_DONE)
    else $error("division did not finish after the last quotient bit");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result shown without a finished report");

  a_busy_no_byte: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.byte_in && !cmd.clear && !cmd.empty)
    else $error("counter update while a report is in progress");

endmodule

[hdl/pbc_dp.sv]
// Datapath of the PRBS9 checker: pattern generator, saturating counters,
// report multiplier, restoring divider and result registers. Uses pbc_pkg.

module pbc_dp #(
  parameter int MAX_PAYLOAD = pbc_pkg::MAX_PAYLOAD
) (
  input  logic           clk,
  input  logic           rst,
  input  pbc_pkg::cmd_t  cmd,
  input  logic [8:0]     exp_len,
  input  logic [7:0]     rx_byte,
  input  logic           last_byte,
  input  logic [31:0]    sent_packets,
  output logic [31:0]    bit_errors,
  output logic [31:0]    total_bits,
  output logic [31:0]    packets_received,
  output logic [31:0]    packets_lost,
  output logic [19:0]    ber_ppm
);

  localparam logic [12:0] MaxPay = 13'(MAX_PAYLOAD);

  // 8 LFSR shifts, MSB first: returns {next state, pattern byte}
  function automatic logic [16:0] pat_byte(input logic [8:0] s);
    logic [8:0] r;
    logic [7:0] b;
    logic       fb;
    r = s;
    b = '0;
    for (int k = 0; k < 8; k++) begin
      fb = r[8] ^ r[4];
      r  = {r[7:0], fb};
      b  = {b[6:0], fb};
    end
    return {r, b};
  endfunction

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [12:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? '1 : s[31:0];
  endfunction

  logic [8:0]  lfsr;
  logic [8:0]  byte_pos;
  logic [31:0] err_cnt;
  logic [31:0] bit_cnt;
  logic [31:0] pkt_cnt;

  logic [31:0]                 sent_q;
  logic [pbc_pkg::PROD_W-1:0]  prod;
  logic [31:0]                 rem;
  logic [pbc_pkg::QUO_BITS-1:0] low;
  logic [pbc_pkg::QUO_BITS-1:0] quo;

  logic [8:0]  eff_len;
  logic [16:0] pat;
  logic        in_range;
  logic [8:0]  pos_after;
  logic [8:0]  missing;
  logic [12:0] err_inc;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign eff_len   = ({4'b0, exp_len} > MaxPay) ? MaxPay[8:0] : exp_len;
  assign pat       = pat_byte(lfsr);
  assign in_range  = (byte_pos < eff_len);
  assign pos_after = in_range ? byte_pos + 9'd1 : byte_pos;
  assign missing   = (last_byte && (pos_after < eff_len)) ? eff_len - pos_after : '0;
  assign err_inc   = (in_range ? 13'(ones8(rx_byte ^ pat[7:0])) : 13'd0)
                   + {1'b0, missing, 3'b000};

  assign shifted = {rem, low[pbc_pkg::QUO_BITS-1]};
  assign diff    = shifted - {1'b0, bit_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr     <= pbc_pkg::LFSR_SEED;
      byte_pos <= '0;
      err_cnt  <= '0;
      bit_cnt  <= '0;
      pkt_cnt  <= '0;
    end else if (cmd.clear) begin
      lfsr     <= pbc_pkg::LFSR_SEED;
      byte_pos <= '0;
      err_cnt  <= '0;
      bit_cnt  <= '0;
      pkt_cnt  <= '0;
    end else if (cmd.empty) begin
      lfsr     <= pbc_pkg::LFSR_SEED;
      byte_pos <= '0;
      pkt_cnt  <= sat_add(pkt_cnt, 13'd1);
    end else if (cmd.byte_in) begin
      err_cnt <= sat_add(err_cnt, err_inc);
      if (last_byte) begin
        lfsr     <= pbc_pkg::LFSR_SEED;
        byte_pos <= '0;
        bit_cnt  <= sat_add(bit_cnt, {1'b0, eff_len, 3'b000});
        pkt_cnt  <= sat_add(pkt_cnt, 13'd1);
      end else begin
        lfsr     <= in_range ? pat[16:8] : lfsr;
        byte_pos <= pos_after;
      end
    end
  end

  // report arithmetic; quotient only matters when errors < bits, so it fits
  always_ff @(posedge clk) begin
    if (cmd.rpt_start) begin
      sent_q <= sent_packets;
      prod   <= err_cnt * pbc_pkg::PPM_SCALE;
    end
    if (cmd.div_load) begin
      rem <= prod[pbc_pkg::PROD_W-1:pbc_pkg::QUO_BITS];
      low <= prod[pbc_pkg::QUO_BITS-1:0];
      quo <= '0;
    end
    if (cmd.div_step) begin
      low <= {low[pbc_pkg::QUO_BITS-2:0], 1'b0};
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[pbc_pkg::QUO_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[pbc_pkg::QUO_BITS-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      bit_errors       <= err_cnt;
      total_bits       <= bit_cnt;
      packets_received <= pkt_cnt;
      packets_lost     <= (sent_q > pkt_cnt) ? sent_q - pkt_cnt : '0;
      if (bit_cnt == '0) begin
        ber_ppm <= '0;
      end else if (err_cnt >= bit_cnt) begin
        ber_ppm <= pbc_pkg::PPM_SCALE;
      end else begin
        ber_ppm <= quo;
      end
    end
  end

endmodule

[hdl/prbs9_ber_checker_unit.sv]
// Top level of the PRBS9 bit error rate checker: register port and the
// controller/datapath pair. Depends on pbc_pkg, pbc_ctrl and pbc_dp.
//
// Usage
//  - Input channel (in_valid/in_stall): one transaction per action. Clear,
//    received byte and empty packet are absorbed in the cycle they are accepted,
//    so a byte stream runs at one byte per clock while no report stalls it.
//  - A report transaction stalls the input while it runs: the 32x20 multiply
//    of errors by one million at acceptance, the divider load (S_MUL), the
//    restoring divider (one quotient bit per cycle, 20 quotient bits), then
//    the result load.
//  - Output channel (out_valid/out_stall): a single result register. Byte
//    traffic keeps flowing while a result waits; only a following report
//    holds in its final cycle until the pending result has been taken.
//  - APB register port: expected packet length at byte address 0; write it
//    only when idle, which the block itself does not enforce.
//  - Reset (rst, synchronous): counters zero, pattern at the all-ones seed,
//    expected length back to 64, output channel empty.

module prbs9_ber_checker_unit #(
  parameter int MAX_PAYLOAD = pbc_pkg::MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  input  logic [31:0] sent_packets,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] bit_errors,
  output logic [31:0] total_bits,
  output logic [31:0] packets_received,
  output logic [31:0] packets_lost,
  output logic [19:0] ber_ppm,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]     exp_len;
  pbc_pkg::cmd_t  cmd;
  logic           reg_wr;

  // register index is the word address bit; byte lane bits are ignored
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == pbc_pkg::REG_EXP_LEN);
  assign prdata = (paddr[2] == pbc_pkg::REG_EXP_LEN) ? {23'b0, exp_len} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= pbc_pkg::LEN_RESET;
    end else if (reg_wr) begin
      exp_len <= pwdata[8:0];
    end
  end

  pbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pbc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .exp_len          (exp_len),
    .rx_byte          (rx_byte),
    .last_byte        (last_byte),
    .sent_packets     (sent_packets),
    .bit_errors       (bit_errors),
    .total_bits       (total_bits),
    .packets_received (packets_received),
    .packets_lost     (packets_lost),
    .ber_ppm          (ber_ppm)
  );

endmodule

[sim/tb_prbs9_ber_checker_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for prbs9_ber_checker_unit: a queue-fed driver, a result
// monitor and an in-bench model of the PRBS9 error counters. Depends on pbc_pkg.

module tb_prbs9_ber_checker_unit;

  localparam int WATCHDOG_LIMIT = 3000;  // idle cycles before giving up
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 30;    // margin for a report to finish in the block
  localparam int MAX_REPORTED   = 10;

  // one input transaction
  typedef struct {
    pbc_pkg::action_t act;
    logic [7:0]       rx;
    logic             last;
    logic [31:0]      sent;
  } rx_item_t;

  // one report transaction
  typedef struct {
    logic [31:0] errs;
    logic [31:0] bits;
    logic [31:0] rcvd;
    logic [31:0] lost;
    logic [19:0] ppm;
  } ber_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = pbc_pkg::ACT_CLEAR;
  logic [7:0]  rx_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic [31:0] sent_packets = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] bit_errors;
  logic [31:0] total_bits;
  logic [31:0] packets_received;
  logic [31:0] packets_lost;
  logic [19:0] ber_ppm;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  prbs9_ber_checker_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model state: pattern generator, packet position and the three counters.
  // ---------------------------------------------------------------------------
  logic [8:0]  pay_len  = pbc_pkg::LEN_RESET;
  logic [8:0]  pat_lfsr = pbc_pkg::LFSR_SEED;
  logic [8:0]  pat_pos  = '0;
  logic [31:0] err_cnt  = '0;
  logic [31:0] bit_cnt  = '0;
  logic [31:0] pkt_cnt  = '0;

  rx_item_t    tx_items[$];   // stimulus waiting for the driver
  ber_report_t report_q[$];   // reports the block owes us
  int          fail_count = 0;
  bit          hold_req = 1'b0;
  int          gen_eff = 64;  // effective length as the generator sees it

  // eight steps of x^9 + x^5 + 1, MSB first; returns {next state, byte}
  function automatic logic [16:0] prbs9_next(input logic [8:0] s);
    logic [8:0] st;
    logic [7:0] b;
    logic       fb;
    int         k;
    st = s;
    b  = '0;
    for (k = 0; k < 8; k++) begin
      fb = st[8] ^ st[4];
      st = {st[7:0], fb};
      b  = {b[6:0], fb};
    end
    return {st, b};
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = {32'h0, a} + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Apply one accepted transaction to the counters; a report queues its result.
  task automatic update_ber_counts(input rx_item_t it);
    ber_report_t r;
    logic [16:0] nx;
    logic [63:0] ppm;
    int          n;
    n = (int'(pay_len) > pbc_pkg::MAX_PAYLOAD) ? pbc_pkg::MAX_PAYLOAD : int'(pay_len);
    case (it.act)
      pbc_pkg::ACT_CLEAR: begin
        err_cnt  = '0;
        bit_cnt  = '0;
        pkt_cnt  = '0;
        pat_lfsr = pbc_pkg::LFSR_SEED;
        pat_pos  = '0;
      end
      pbc_pkg::ACT_BYTE: begin
        // bytes past the effective length leave the pattern alone
        if (int'(pat_pos) < n) begin
          nx       = prbs9_next(pat_lfsr);
          pat_lfsr = nx[16:8];
          err_cnt  = sat_add(err_cnt, 64'($countones(it.rx ^ nx[7:0])));
          pat_pos  = pat_pos + 9'd1;
        end
        if (it.last) begin
          // short packet: every missing byte counts as eight errors
          if (int'(pat_pos) < n)
            err_cnt = sat_add(err_cnt, 64'(n - int'(pat_pos)) * 64'd8);
          bit_cnt  = sat_add(bit_cnt, 64'(n) * 64'd8);
          pkt_cnt  = sat_add(pkt_cnt, 64'd1);
          pat_lfsr = pbc_pkg::LFSR_SEED;
          pat_pos  = '0;
        end
      end
      pbc_pkg::ACT_EMPTY: begin
        // a partial packet keeps its errors but adds no bits
        pkt_cnt  = sat_add(pkt_cnt, 64'd1);
        pat_lfsr = pbc_pkg::LFSR_SEED;
        pat_pos  = '0;
      end
      default: begin
        ppm = '0;
        if (bit_cnt != 0) begin
          ppm = (64'(err_cnt) * 64'(pbc_pkg::PPM_SCALE)) / 64'(bit_cnt);
          if (ppm > 64'(pbc_pkg::PPM_SCALE)) ppm = 64'(pbc_pkg::PPM_SCALE);
        end
        r.errs = err_cnt;
        r.bits = bit_cnt;
        r.rcvd = pkt_cnt;
        r.lost = (it.sent > pkt_cnt) ? it.sent - pkt_cnt : 32'h0;
        r.ppm  = ppm[19:0];
        report_q.push_back(r);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pops the next item, waits a drawn gap after each transaction and
  // holds the payload steady while the block stalls.
  // ---------------------------------------------------------------------------
  rx_item_t cur_item;
  int       gap_left = 0;
  bit       no_gaps = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        update_ber_counts(cur_item);
        // occasionally switch between gappy and back-to-back stretches
        if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
        gap_left = no_gaps ? 0 : $urandom_range(0, 15);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tx_items.size() != 0) begin
          cur_item     = tx_items.pop_front();
          action       <= cur_item.act;
          rx_byte      <= cur_item.rx;
          last_byte    <= cur_item.last;
          sent_packets <= cur_item.sent;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each report transaction against the oldest expectation,
  // then stalls for a drawn number of cycles. A hold request from the
  // sequence makes it sit on the output for a long stretch.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left  = 0;

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTED)
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ber_report_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          if (fail_count < MAX_REPORTED)
            $display("%0t: unexpected report transaction", $realtime);
          fail_count++;
        end else begin
          exp_r = report_q.pop_front();
          compare_field("bit_errors", exp_r.errs, bit_errors);
          compare_field("total_bits", exp_r.bits, total_bits);
          compare_field("packets_received", exp_r.rcvd, packets_received);
          compare_field("packets_lost", exp_r.lost, packets_lost);
          compare_field("ber_ppm", 32'(exp_r.ppm), 32'(ber_ppm));
        end
        stall_left = $urandom_range(0, 15);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      out_stall <= (hold_left > 0) || (stall_left > 0);
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
    end
  end

  // watchdog: any transaction on either channel or the register port resets it
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle = 0;
      else
        idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input pbc_pkg::action_t a, input logic [7:0] rx,
                            input logic lb, input logic [31:0] sent);
    rx_item_t it;
    it.act  = a;
    it.rx   = rx;
    it.last = lb;
    it.sent = sent;
    tx_items.push_back(it);
  endtask

  // non-byte action with the unused fields randomised
  task automatic queue_ctrl(input pbc_pkg::action_t a, input logic [31:0] sent);
    queue_item(a, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sent);
  endtask

  // Packet of pattern bytes from the seed, a share of them corrupted or all
  // of them inverted; last_byte only when the packet is terminated.
  task automatic send_packet(input int nbytes, input bit terminate, input int flip_pct,
                             input bit invert);
    logic [8:0]  s;
    logic [16:0] nx;
    logic [7:0]  b;
    int          i;
    s = pbc_pkg::LFSR_SEED;
    for (i = 0; i < nbytes; i++) begin
      nx = prbs9_next(s);
      s  = nx[16:8];
      b  = invert ? ~nx[7:0] : nx[7:0];
      if ($urandom_range(0, 99) < flip_pct) b ^= 8'($urandom_range(1, 255));
      queue_item(pbc_pkg::ACT_BYTE, b, terminate && (i == nbytes - 1), $urandom);
    end
  endtask

  // Mostly well-formed packets; the rest are reports, empties, clears, stray
  // bytes and packets broken off part way.
  task automatic run_random(input int count);
    int made, r, len, fp;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if (gen_eff == 0) len = $urandom_range(1, 3);
        else if ($urandom_range(0, 99) < 60) len = gen_eff;
        else len = $urandom_range(1, gen_eff + 3);
        // keep the item count close to the request
        if (len > count - made) len = count - made;
        case ($urandom_range(0, 3))
          0: fp = 0;
          1: fp = 3;
          2: fp = 25;
          default: fp = 100;
        endcase
        if ($urandom_range(0, 9) == 0) begin
          // broken-off packet followed by an empty, a report or a clear
          len = $urandom_range(1, len);
          send_packet(len, 1'b0, fp, 1'b0);
          case ($urandom_range(0, 2))
            0: queue_ctrl(pbc_pkg::ACT_EMPTY, $urandom);
            1: queue_ctrl(pbc_pkg::ACT_REPORT, $urandom);
            default: queue_ctrl(pbc_pkg::ACT_CLEAR, $urandom);
          endcase
          made += len + 1;
        end else begin
          send_packet(len, 1'b1, fp, 1'b0);
          made += len;
        end
      end else begin
        if (r < 82)
          queue_ctrl(pbc_pkg::ACT_REPORT,
                     $urandom_range(0, 1) ? $urandom : $urandom_range(0, 60));
        else if (r < 88)
          queue_ctrl(pbc_pkg::ACT_EMPTY, $urandom);
        else if (r < 91)
          queue_ctrl(pbc_pkg::ACT_CLEAR, $urandom);
        else
          queue_item(pbc_pkg::ACT_BYTE, 8'($urandom_range(0, 255)),
                     $urandom_range(0, 3) == 0, $urandom);
        made++;
      end
    end
  endtask

  // wait until the block has drained and owes nothing, plus its latency
  task automatic settle();
    @(negedge clk);
    while (tx_items.size() != 0 || in_valid || report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the expected length: setup then access; junk in the upper data bits
  task automatic set_len(input logic [8:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {pbc_pkg::REG_EXP_LEN, 2'b00};
    pwdata  <= ($urandom << 9) | 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pay_len = v;
    gen_eff = (int'(v) > pbc_pkg::MAX_PAYLOAD) ? pbc_pkg::MAX_PAYLOAD : int'(v);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset length of 64
    queue_ctrl(pbc_pkg::ACT_CLEAR, $urandom);
    queue_ctrl(pbc_pkg::ACT_REPORT, 32'h0);            // nothing counted yet
    queue_ctrl(pbc_pkg::ACT_EMPTY, $urandom);          // empty packet only counts
    queue_ctrl(pbc_pkg::ACT_REPORT, 32'hFFFF_FFFF);
    send_packet(3, 1'b1, 0, 1'b0);                     // short: 61 missing bytes
    queue_item(pbc_pkg::ACT_BYTE, 8'hFF, 1'b0, $urandom);
    queue_item(pbc_pkg::ACT_BYTE, 8'h00, 1'b0, $urandom);
    queue_ctrl(pbc_pkg::ACT_REPORT, 32'd1);            // report in the middle of a packet
    queue_ctrl(pbc_pkg::ACT_EMPTY, $urandom);          // empty during a packet
    queue_ctrl(pbc_pkg::ACT_REPORT, $urandom);
    queue_item(pbc_pkg::ACT_CLEAR, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    queue_item(pbc_pkg::ACT_REPORT, 8'hFF, 1'b1, 32'h0);
    run_random(200);
    settle();

    // length 1 with the long receiver hold-off: reports pile up behind it
    set_len(9'd1);
    hold_req = 1'b1;
    send_packet(3, 1'b1, 0, 1'b1);                     // extra bytes are ignored
    queue_ctrl(pbc_pkg::ACT_REPORT, $urandom);
    queue_ctrl(pbc_pkg::ACT_REPORT, $urandom);         // waits behind the held result
    run_random(80);
    settle();

    // length 2: errors beyond the bit count saturate the ratio
    set_len(9'd2);
    queue_ctrl(pbc_pkg::ACT_CLEAR, $urandom);
    send_packet(2, 1'b1, 0, 1'b1);
    send_packet(1, 1'b0, 0, 1'b1);
    queue_ctrl(pbc_pkg::ACT_REPORT, $urandom);
    run_random(40);
    settle();

    set_len(9'd256);
    run_random(300);
    settle();

    // zero length compares nothing and only counts packets
    set_len(9'd0);
    send_packet(2, 1'b1, 0, 1'b0);
    queue_ctrl(pbc_pkg::ACT_REPORT, $urandom);
    run_random(40);
    settle();

    // above the maximum: limited to MAX_PAYLOAD
    set_len(9'd511);
    run_random(60);
    settle();

    repeat (4) begin
      set_len(9'($urandom_range(3, 24)));
      run_random(40);
      settle();
    end

    if (report_q.size() != 0) begin
      $display("%0d report transactions never arrived", report_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[prbs9_ber_checker_unit.f]
hdl/pbc_pkg.sv
hdl/pbc_ctrl.sv
hdl/pbc_dp.sv
hdl/prbs9_ber_checker_unit.sv
sim/tb_prbs9_ber_checker_unit.sv
